>>> sv/assert_macros.svh
// Assertion macros for the elevation obstacle detector checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high
`define EOD_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds across reset
`define EOD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> sv/eod_pkg.sv
package eod_pkg;

  localparam int GRID_DIM   = 128;
  localparam int COORD_W    = 7;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int HEIGHT_W   = 16;
  localparam int ENTRY_W    = HEIGHT_W + 1;
  localparam int MAX_WINDOW = 64;
  localparam int GRAD_W     = HEIGHT_W + 3;
  localparam int SQ_W       = 2 * GRAD_W;
  localparam int MAG_W      = 20;
  localparam int ROOT_STEPS = GRAD_W;

  localparam logic [2:0] REG_GRID_SIZE         = 3'd0;
  localparam logic [2:0] REG_OBSTACLE_GRADIENT = 3'd1;
  localparam logic [2:0] REG_STEP_LIMIT        = 3'd2;
  localparam logic [2:0] REG_WINDOW_SIZE       = 3'd3;

  localparam logic [1:0] CAUSE_NONE     = 2'd0;
  localparam logic [1:0] CAUSE_GRADIENT = 2'd1;
  localparam logic [1:0] CAUSE_STEP     = 2'd2;

  localparam logic CMD_WRITE = 1'b0;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_EVAL,
    KIND_BORDER
  } kind_t;

  typedef struct packed {
    kind_t                        kind;
    logic [COORD_W-1:0]           row;
    logic [COORD_W-1:0]           col;
    logic signed [HEIGHT_W-1:0]   elevation;
    logic                         cell_valid;
  } req_t;

  typedef struct packed {
    logic [7:0]  grid_size;
    logic [15:0] obstacle_gradient;
    logic [15:0] step_limit;
    logic [6:0]  window_size;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WIN,
    ST_GRAD,
    ST_SQX,
    ST_SQY,
    ST_ROOT,
    ST_JUDGE,
    ST_DIV,
    ST_CLIP,
    ST_SCAN,
    ST_SCAN_END,
    ST_STEP,
    ST_DONE
  } state_t;

endpackage

>>> sv/eod_front.sv
module eod_front (
  input  logic                       command,
  input  logic [eod_pkg::COORD_W-1:0] row,
  input  logic [eod_pkg::COORD_W-1:0] col,
  input  logic signed [eod_pkg::HEIGHT_W-1:0] elevation,
  input  logic                       cell_valid,
  input  eod_pkg::cfg_t              cfg,
  output eod_pkg::req_t              entry
);

  logic [7:0] n;
  logic [7:0] r8;
  logic [7:0] c8;
  logic       interior;

  always_comb begin
    n  = (cfg.grid_size > 8'(eod_pkg::GRID_DIM)) ? 8'(eod_pkg::GRID_DIM) : cfg.grid_size;
    r8 = {1'b0, row};
    c8 = {1'b0, col};
    interior = (r8 >= 8'd1) && (c8 >= 8'd1) && (r8 + 8'd1 < n) && (c8 + 8'd1 < n);
    entry.row        = row;
    entry.col        = col;
    entry.elevation  = elevation;
    entry.cell_valid = cell_valid;
    if (command == eod_pkg::CMD_WRITE) begin
      entry.kind = eod_pkg::KIND_WRITE;
    end else if (interior) begin
      entry.kind = eod_pkg::KIND_EVAL;
    end else begin
      entry.kind = eod_pkg::KIND_BORDER;
    end
  end

endmodule

>>> sv/eod_queue.sv
module eod_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  eod_pkg::req_t din,
  input  logic          pop,
  output eod_pkg::req_t dout,
  output logic          not_empty,
  output logic          full
);

  eod_pkg::req_t slots [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    count;

  assign dout      = slots[rptr];
  assign not_empty = (count != 2'd0);
  assign full      = (count == 2'd2);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

>>> sv/eod_back.sv
module eod_back (
  input  logic                         clk,
  input  logic                         rst,
  input  eod_pkg::cfg_t                cfg,
  input  eod_pkg::req_t                head,
  input  logic                         head_ok,
  output logic                         pop,
  output logic                         res_valid,
  input  logic                         res_stall,
  output logic [eod_pkg::COORD_W-1:0]  out_row,
  output logic [eod_pkg::COORD_W-1:0]  out_col,
  output logic [eod_pkg::MAG_W-1:0]    gradient_magnitude,
  output logic                         has_gradient,
  output logic [1:0]                   obstacle_cause
);

  localparam int CW = eod_pkg::COORD_W;
  localparam int HW = eod_pkg::HEIGHT_W;
  localparam int GW = eod_pkg::GRAD_W;
  localparam int SW = eod_pkg::SQ_W;

  eod_pkg::state_t state;
  eod_pkg::state_t state_next;

  logic [eod_pkg::ENTRY_W-1:0] mem [eod_pkg::GRID_DIM * eod_pkg::GRID_DIM];
  logic [eod_pkg::ENTRY_W-1:0] mem_q;
  logic [eod_pkg::ADDR_W-1:0]  raddr;
  logic                        mem_we;

  eod_pkg::req_t        cur;
  logic [3:0]           k;
  logic [1:0]           wr;
  logic [1:0]           wc;
  logic signed [HW-1:0] h [9];
  logic                 win_ok;
  logic signed [GW-1:0] gx;
  logic signed [GW-1:0] gy;
  logic signed [SW-1:0] gx2;
  logic signed [SW-1:0] gy2;
  logic [SW-1:0]        sq;
  logic [SW-1:0]        sq_next;
  logic [31:0]          th;
  logic [SW-1:0]        rt_x;
  logic [SW-1:0]        rt_res;
  logic [SW-1:0]        rt_bit;
  logic [SW-1:0]        rt_trial;
  logic [SW-1:0]        rt_res_next;
  logic [4:0]           it;
  logic [eod_pkg::MAG_W-1:0] mag;
  logic                 has;
  logic [1:0]           cause;
  logic [6:0]           w;
  logic [7:0]           n;
  logic [CW-1:0]        dr;
  logic [CW-1:0]        dc;
  logic [CW-1:0]        remr;
  logic [CW-1:0]        remc;
  logic [CW-1:0]        qr;
  logic [CW-1:0]        qc;
  logic [7:0]           shr;
  logic [7:0]           shc;
  logic [2:0]           dcnt;
  logic [CW-1:0]        si;
  logic [CW-1:0]        sj;
  logic [CW-1:0]        c0;
  logic [7:0]           r1;
  logic [7:0]           c1;
  logic [7:0]           r1_next;
  logic [7:0]           c1_next;
  logic                 pend;
  logic                 found;
  logic signed [HW-1:0] mn;
  logic signed [HW+1:0] diff;
  logic                 load_out;

  always_comb begin
    n = (cfg.grid_size > 8'(eod_pkg::GRID_DIM)) ? 8'(eod_pkg::GRID_DIM) : cfg.grid_size;
    if (cfg.window_size == 7'd0) begin
      w = 7'd1;
    end else if (cfg.window_size > 7'(eod_pkg::MAX_WINDOW)) begin
      w = 7'(eod_pkg::MAX_WINDOW);
    end else begin
      w = cfg.window_size;
    end
    gx2      = gx * gx;
    gy2      = gy * gy;
    sq_next  = sq + SW'(gy2);
    rt_trial = rt_res + rt_bit;
    rt_res_next = (rt_x >= rt_trial) ? ((rt_res >> 1) + rt_bit) : (rt_res >> 1);
    shr = {remr, dr[CW-1]};
    shc = {remc, dc[CW-1]};
    r1_next = ({1'b0, qr} + {1'b0, w} < n) ? {1'b0, qr} + {1'b0, w} : n;
    c1_next = ({1'b0, qc} + {1'b0, w} < n) ? {1'b0, qc} + {1'b0, w} : n;
    diff = (HW+2)'(h[4]) - (HW+2)'(mn);
    load_out = !res_valid || !res_stall;
    mem_we = 1'b0;
    raddr  = {si, sj};
    pop    = 1'b0;
    state_next = state;
    unique case (state)
      eod_pkg::ST_IDLE: begin
        if (head_ok) begin
          pop = 1'b1;
          unique case (head.kind)
            eod_pkg::KIND_WRITE:  mem_we = 1'b1;
            eod_pkg::KIND_EVAL:   state_next = eod_pkg::ST_WIN;
            eod_pkg::KIND_BORDER: state_next = eod_pkg::ST_DONE;
            default:              state_next = eod_pkg::ST_IDLE;
          endcase
        end
      end
      eod_pkg::ST_WIN: begin
        raddr = {CW'(cur.row + CW'(wr) - CW'(1)), CW'(cur.col + CW'(wc) - CW'(1))};
        if (k == 4'd9) state_next = eod_pkg::ST_GRAD;
      end
      eod_pkg::ST_GRAD:  state_next = win_ok ? eod_pkg::ST_SQX : eod_pkg::ST_DONE;
      eod_pkg::ST_SQX:   state_next = eod_pkg::ST_SQY;
      eod_pkg::ST_SQY:   state_next = eod_pkg::ST_ROOT;
      eod_pkg::ST_ROOT: begin
        if (it == 5'(eod_pkg::ROOT_STEPS - 1)) state_next = eod_pkg::ST_JUDGE;
      end
      eod_pkg::ST_JUDGE: state_next = (sq > SW'(th)) ? eod_pkg::ST_DONE : eod_pkg::ST_DIV;
      eod_pkg::ST_DIV: begin
        if (dcnt == 3'(CW - 1)) state_next = eod_pkg::ST_CLIP;
      end
      eod_pkg::ST_CLIP:  state_next = eod_pkg::ST_SCAN;
      eod_pkg::ST_SCAN: begin
        if (({1'b0, sj} + 8'd1 == c1) && ({1'b0, si} + 8'd1 == r1)) begin
          state_next = eod_pkg::ST_SCAN_END;
        end
      end
      eod_pkg::ST_SCAN_END: state_next = eod_pkg::ST_STEP;
      eod_pkg::ST_STEP:     state_next = eod_pkg::ST_DONE;
      eod_pkg::ST_DONE: begin
        if (load_out) state_next = eod_pkg::ST_IDLE;
      end
      default: state_next = eod_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[{head.row, head.col}] <= {head.cell_valid, head.elevation};
    end
    mem_q <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eod_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      eod_pkg::ST_IDLE: begin
        cur    <= head;
        k      <= 4'd0;
        wr     <= 2'd0;
        wc     <= 2'd0;
        win_ok <= 1'b1;
        mag    <= '0;
        has    <= 1'b0;
        cause  <= eod_pkg::CAUSE_NONE;
      end
      eod_pkg::ST_WIN: begin
        k <= k + 4'd1;
        if (wc == 2'd2) begin
          wc <= 2'd0;
          wr <= wr + 2'd1;
        end else begin
          wc <= wc + 2'd1;
        end
        if (k != 4'd0) begin
          for (int i = 0; i < 8; i++) h[i] <= h[i+1];
          h[8]   <= mem_q[HW-1:0];
          win_ok <= win_ok & mem_q[HW];
        end
      end
      eod_pkg::ST_GRAD: begin
        gx <= (GW'(h[6]) + GW'(h[7]) + GW'(h[8])) - (GW'(h[0]) + GW'(h[1]) + GW'(h[2]));
        gy <= (GW'(h[2]) + GW'(h[5]) + GW'(h[8])) - (GW'(h[0]) + GW'(h[3]) + GW'(h[6]));
      end
      eod_pkg::ST_SQX: sq <= SW'(gx2);
      eod_pkg::ST_SQY: begin
        sq     <= sq_next;
        th     <= 32'(cfg.obstacle_gradient) * 32'(cfg.obstacle_gradient);
        rt_x   <= sq_next;
        rt_res <= '0;
        rt_bit <= SW'(1) << (2 * (eod_pkg::ROOT_STEPS - 1));
        it     <= '0;
      end
      eod_pkg::ST_ROOT: begin
        if (rt_x >= rt_trial) rt_x <= rt_x - rt_trial;
        rt_res <= rt_res_next;
        rt_bit <= rt_bit >> 2;
        it     <= it + 5'd1;
      end
      eod_pkg::ST_JUDGE: begin
        mag  <= rt_res[eod_pkg::MAG_W-1:0];
        has  <= 1'b1;
        if (sq > SW'(th)) cause <= eod_pkg::CAUSE_GRADIENT;
        dr   <= cur.row;
        dc   <= cur.col;
        remr <= '0;
        remc <= '0;
        dcnt <= '0;
      end
      eod_pkg::ST_DIV: begin
        dr   <= dr << 1;
        dc   <= dc << 1;
        dcnt <= dcnt + 3'd1;
        if (shr >= {1'b0, w}) begin
          remr <= CW'(shr - {1'b0, w});
          qr   <= {qr[CW-2:0], 1'b1};
        end else begin
          remr <= shr[CW-1:0];
          qr   <= {qr[CW-2:0], 1'b0};
        end
        if (shc >= {1'b0, w}) begin
          remc <= CW'(shc - {1'b0, w});
          qc   <= {qc[CW-2:0], 1'b1};
        end else begin
          remc <= shc[CW-1:0];
          qc   <= {qc[CW-2:0], 1'b0};
        end
      end
      eod_pkg::ST_CLIP: begin
        si    <= qr;
        sj    <= qc;
        c0    <= qc;
        r1    <= r1_next;
        c1    <= c1_next;
        pend  <= 1'b0;
        found <= 1'b0;
      end
      eod_pkg::ST_SCAN, eod_pkg::ST_SCAN_END: begin
        pend <= 1'b1;
        if (pend && mem_q[HW]) begin
          if (!found || $signed(mem_q[HW-1:0]) < mn) mn <= mem_q[HW-1:0];
          found <= 1'b1;
        end
        if ({1'b0, sj} + 8'd1 == c1) begin
          sj <= c0;
          si <= si + CW'(1);
        end else begin
          sj <= sj + CW'(1);
        end
      end
      eod_pkg::ST_STEP: begin
        if (found && diff > $signed({2'b00, cfg.step_limit})) cause <= eod_pkg::CAUSE_STEP;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= (state == eod_pkg::ST_DONE);
    end
  end

  always_ff @(posedge clk) begin
    if (load_out && state == eod_pkg::ST_DONE) begin
      out_row            <= cur.row;
      out_col            <= cur.col;
      gradient_magnitude <= mag;
      has_gradient       <= has;
      obstacle_cause     <= cause;
    end
  end

endmodule

>>> sv/elevation_obstacle_detector.sv
// channel | valid / stall        | payload
// req     | req_valid/req_stall  | command, row, col, elevation, cell_valid
// res     | res_valid/res_stall  | out_row, out_col, gradient_magnitude,
//         |                      | has_gradient, obstacle_cause
// cfg     | cfg_we               | cfg_index, cfg_data
// A write goes straight into the grid in the back end; evaluate ends early for a border
// cell, after the window read for an invalid window, after the square root for a steep
// gradient, and otherwise runs the minimum scan (one grid read per cycle, up to
// 4096 cells). The result is registered.
// The 19-step square root and the single memory port set the evaluate time.
// Reset is synchronous; the height grid is not cleared.
// A two-entry queue takes requests while the back end works or res stalls.
module elevation_obstacle_detector (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  req_valid,
  output logic                                  req_stall,
  input  logic                                  command,
  input  logic [eod_pkg::COORD_W-1:0]           row,
  input  logic [eod_pkg::COORD_W-1:0]           col,
  input  logic signed [eod_pkg::HEIGHT_W-1:0]   elevation,
  input  logic                                  cell_valid,
  output logic                                  res_valid,
  input  logic                                  res_stall,
  output logic [eod_pkg::COORD_W-1:0]           out_row,
  output logic [eod_pkg::COORD_W-1:0]           out_col,
  output logic [eod_pkg::MAG_W-1:0]             gradient_magnitude,
  output logic                                  has_gradient,
  output logic [1:0]                            obstacle_cause,
  input  logic                                  cfg_we,
  input  logic [2:0]                            cfg_index,
  input  logic [15:0]                           cfg_data
);

  eod_pkg::cfg_t cfg;
  eod_pkg::req_t entry;
  eod_pkg::req_t head;
  logic          head_ok;
  logic          pop;
  logic          full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_size         <= 8'd100;
      cfg.obstacle_gradient <= 16'd102;
      cfg.step_limit        <= 16'd128;
      cfg.window_size       <= 7'd20;
    end else if (cfg_we) begin
      case (cfg_index)
        eod_pkg::REG_GRID_SIZE:         cfg.grid_size         <= cfg_data[7:0];
        eod_pkg::REG_OBSTACLE_GRADIENT: cfg.obstacle_gradient <= cfg_data;
        eod_pkg::REG_STEP_LIMIT:        cfg.step_limit        <= cfg_data;
        eod_pkg::REG_WINDOW_SIZE:       cfg.window_size       <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  assign req_stall = full;

  eod_front u_front (
    .command    (command),
    .row        (row),
    .col        (col),
    .elevation  (elevation),
    .cell_valid (cell_valid),
    .cfg        (cfg),
    .entry      (entry)
  );

  eod_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (req_valid && !full),
    .din       (entry),
    .pop       (pop),
    .dout      (head),
    .not_empty (head_ok),
    .full      (full)
  );

  eod_back u_back (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .head               (head),
    .head_ok            (head_ok),
    .pop                (pop),
    .res_valid          (res_valid),
    .res_stall          (res_stall),
    .out_row            (out_row),
    .out_col            (out_col),
    .gradient_magnitude (gradient_magnitude),
    .has_gradient       (has_gradient),
    .obstacle_cause     (obstacle_cause)
  );

endmodule

>>> sv/eod_checker.sv
`include "assert_macros.svh"

module eod_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          res_valid,
  input logic                          res_stall,
  input logic [eod_pkg::MAG_W-1:0]     gradient_magnitude,
  input logic                          has_gradient,
  input logic [1:0]                    obstacle_cause
);

  `EOD_ASSERT(a_res_hold, clk, rst, res_valid && res_stall |=> res_valid, "result dropped")
  `EOD_ASSERT(a_no_grad_zero, clk, rst, res_valid && !has_gradient |-> gradient_magnitude == '0, "stray magnitude")
  `EOD_ASSERT(a_cause_needs_grad, clk, rst, res_valid && obstacle_cause != eod_pkg::CAUSE_NONE |-> has_gradient, "stray cause")
  `EOD_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !res_valid, "result after reset")

endmodule

bind elevation_obstacle_detector eod_checker u_eod_checker (
  .clk                (clk),
  .rst                (rst),
  .res_valid          (res_valid),
  .res_stall          (res_stall),
  .gradient_magnitude (gradient_magnitude),
  .has_gradient       (has_gradient),
  .obstacle_cause     (obstacle_cause)
);
